FILE: rtl/lss_pkg.sv
// Shared types, constants and command codes for the LIFO stack with sort unit.
// Used by every module under rtl/ except lss_ram; depends on nothing else.
`default_nettype none

package lss_pkg;

	// Capacity and derived widths
	localparam int DEPTH   = 16;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int WORD_W  = 32;
	localparam int ENTRY_W = 5;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// Operation codes carried in the request kind field
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_SORT = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic signed [WORD_W-1:0] top_value;
		logic [ENTRY_W-1:0]       entry_count;
		logic                     is_empty;
		logic                     is_full;
		logic                     underflow;
		logic                     overflow;
	} res_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WB,
		ST_TOP_RD,
		ST_TOP_EMIT
	} state_t;

	// Controller to datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_PUSH,
		CMD_PUSH_OVF,
		CMD_POP_UNDER,
		CMD_POP_LAST,
		CMD_POP,
		CMD_NOP_EMIT,
		CMD_SORT_START,
		CMD_SORT_RD,
		CMD_SORT_CMP,
		CMD_SORT_WB,
		CMD_TOP_RD,
		CMD_TOP_EMIT
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic single;
		logic few;
		logic i_last;
		logic j_last;
	} dp_stat_t;

	// Commands that load the result register
	function automatic logic cmd_emits(input dp_cmd_t cmd);
		logic emits;
		case (cmd)
			CMD_PUSH, CMD_PUSH_OVF, CMD_POP_UNDER, CMD_POP_LAST,
			CMD_NOP_EMIT, CMD_TOP_EMIT: emits = 1'b1;
			default: emits = 1'b0;
		endcase
		return emits;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lifo_stack_with_sort_unit.sv
// Top level of the LIFO stack with in-place sort: controller plus datapath.
// Depends on lss_pkg, lss_ctrl, lss_dp (and lss_ram below it).
//
//   channel   dir  handshake             payload
//   request   in   req_valid/req_stall   req (req_t: kind, push_value)
//   result    out  res_valid/res_stall   res (res_t: popped, top, count, flags)
//
// Push, overflow, underflow, no-op, pop to empty and sort of 0..1 entries finish from idle.
// Pop leaving entries also passes ST_TOP_EMIT (registered RAM read fetches the new top).
// Sort of n >= 2 entries runs the single compare-exchange step over each pair,
// each pair taking a read state and a compare state on the entry RAM.
// Reset clears count and control; RAM contents are not cleared.
// A request is taken only in idle with the result register free or draining.
`default_nettype none

module lifo_stack_with_sort_unit
	import lss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_kind (req.kind),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lss_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.res   (res)
	);

endmodule

`default_nettype wire

FILE: rtl/lss_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
	output logic      [WIDTH-1:0]         rd_a_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic      [WIDTH-1:0]         rd_b_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered reads (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_data <= mem_q[rd_a_addr];
		rd_b_data <= mem_q[rd_b_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/lss_ctrl.sv
// Controller state machine for the stack: request accept, sort sequencing,
// result valid. Depends on lss_pkg.
`default_nettype none

module lss_ctrl
	import lss_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_kind,
	output logic            req_stall,
	output logic            res_valid,
	input  wire logic       res_stall,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         cmd
);

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	// Result register is free when empty or being taken this cycle
	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign res_valid = res_valid_q;

	// State and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_emits(cmd)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Next state and command
	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && out_free) begin
					case (req_kind)
						KIND_PUSH: begin
							cmd = stat.full ? CMD_PUSH_OVF : CMD_PUSH;
						end
						KIND_POP: begin
							if (stat.empty) begin
								cmd = CMD_POP_UNDER;
							end else if (stat.single) begin
								cmd = CMD_POP_LAST;
							end else begin
								cmd     = CMD_POP;
								state_d = ST_TOP_EMIT;
							end
						end
						KIND_SORT: begin
							if (stat.few) begin
								cmd = CMD_NOP_EMIT;
							end else begin
								cmd     = CMD_SORT_START;
								state_d = ST_SORT_RD;
							end
						end
						default: cmd = CMD_NOP_EMIT;
					endcase
				end
			end
			ST_SORT_RD: begin
				cmd     = CMD_SORT_RD;
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				cmd     = CMD_SORT_CMP;
				state_d = stat.j_last ? ST_SORT_WB : ST_SORT_RD;
			end
			ST_SORT_WB: begin
				cmd     = CMD_SORT_WB;
				state_d = stat.i_last ? ST_TOP_RD : ST_SORT_RD;
			end
			ST_TOP_RD: begin
				cmd     = CMD_TOP_RD;
				state_d = ST_TOP_EMIT;
			end
			ST_TOP_EMIT: begin
				if (out_free) begin
					cmd     = CMD_TOP_EMIT;
					state_d = ST_IDLE;
				end else begin
					cmd = CMD_TOP_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while a multi-cycle operation runs");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_emits(cmd) && res_valid_q && res_stall))
		else $error("result register loaded while a stalled result waits");

	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req_kind == KIND_POP && !stat.empty && !stat.single)
		|=> (state_q == ST_TOP_EMIT))
		else $error("pop leaving entries did not go to fetch the new top");
`endif

endmodule

`default_nettype wire

FILE: rtl/lss_dp.sv
// Datapath for the stack: entry RAM, count, cached top, sort indexes and
// result register. Depends on lss_pkg and lss_ram.
`default_nettype none

module lss_dp
	import lss_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req,
	input  wire dp_cmd_t cmd,
	output dp_stat_t     stat,
	output res_t         res
);

	logic [COUNT_W-1:0]       count_q, count_d;
	logic [COUNT_W-1:0]       cnt_m1, cnt_m2;
	logic signed [WORD_W-1:0] top_q, top_d;
	logic signed [WORD_W-1:0] popped_q, popped_d;
	logic signed [WORD_W-1:0] ai_q, ai_d;
	logic [ADDR_W-1:0]        i_q, i_d, j_q, j_d;
	logic                     first_q, first_d;
	res_t                     res_q, res_d;

	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr, rd_a_addr, rd_b_addr;
	logic [WORD_W-1:0]        wr_data, rd_a_data, rd_b_data;
	logic signed [WORD_W-1:0] a_val, b_val, res_pop, res_top;
	logic                     under, over;

	assign cnt_m1 = count_q - COUNT_W'(1);
	assign cnt_m2 = count_q - COUNT_W'(2);

	// Status to the controller
	assign stat.empty  = (count_q == '0);
	assign stat.full   = (count_q == COUNT_W'(DEPTH));
	assign stat.single = (count_q == COUNT_W'(1));
	assign stat.few    = (count_q <= COUNT_W'(1));
	assign stat.i_last = (COUNT_W'(i_q) == cnt_m2);
	assign stat.j_last = (COUNT_W'(j_q) == cnt_m1);

	assign res = res_q;

	lss_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_a_addr(rd_a_addr),
		.rd_a_data(rd_a_data),
		.rd_b_addr(rd_b_addr),
		.rd_b_data(rd_b_data)
	);

	// Command decode, sort compare-exchange, result build
	always_comb begin
		count_d   = count_q;
		top_d     = top_q;
		popped_d  = popped_q;
		ai_d      = ai_q;
		i_d       = i_q;
		j_d       = j_q;
		first_d   = first_q;
		wr_en     = 1'b0;
		wr_addr   = count_q[ADDR_W-1:0];
		wr_data   = req.push_value;
		rd_a_addr = cnt_m1[ADDR_W-1:0];
		rd_b_addr = j_q;
		res_pop   = '0;
		res_top   = top_q;
		under     = 1'b0;
		over      = 1'b0;
		a_val     = first_q ? signed'(rd_a_data) : ai_q;
		b_val     = signed'(rd_b_data);

		case (cmd)
			CMD_PUSH: begin
				wr_en   = 1'b1;
				count_d = count_q + COUNT_W'(1);
				top_d   = req.push_value;
				res_top = req.push_value;
			end
			CMD_PUSH_OVF: over = 1'b1;
			CMD_POP_UNDER: begin
				res_pop = signed'(ALL_ONES);
				under   = 1'b1;
			end
			CMD_POP_LAST: begin
				count_d = '0;
				res_pop = top_q;
			end
			CMD_POP: begin
				// new top sits two below the old count
				count_d   = cnt_m1;
				popped_d  = top_q;
				rd_a_addr = cnt_m2[ADDR_W-1:0];
			end
			CMD_SORT_START: begin
				popped_d = '0;
				i_d      = '0;
				j_d      = ADDR_W'(1);
				first_d  = 1'b1;
			end
			CMD_SORT_RD: begin
				rd_a_addr = i_q;
				rd_b_addr = j_q;
			end
			CMD_SORT_CMP: begin
				// running minimum for slot i stays in ai
				first_d = 1'b0;
				if (a_val > b_val) begin
					wr_en   = 1'b1;
					wr_addr = j_q;
					wr_data = a_val;
					ai_d    = b_val;
				end else begin
					ai_d = a_val;
				end
				if (!stat.j_last) begin
					j_d = j_q + ADDR_W'(1);
				end
			end
			CMD_SORT_WB: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = ai_q;
				i_d     = i_q + ADDR_W'(1);
				j_d     = i_q + ADDR_W'(2);
				first_d = 1'b1;
			end
			CMD_TOP_EMIT: begin
				top_d   = signed'(rd_a_data);
				res_top = signed'(rd_a_data);
				res_pop = popped_q;
			end
			default: ;
		endcase

		res_d.popped_value = res_pop;
		res_d.top_value    = (count_d == '0) ? signed'(ALL_ONES) : res_top;
		res_d.entry_count  = ENTRY_W'(count_d);
		res_d.is_empty     = (count_d == '0);
		res_d.is_full      = (count_d == COUNT_W'(DEPTH));
		res_d.underflow    = under;
		res_d.overflow     = over;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			count_q <= count_d;
			first_q <= first_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		top_q    <= top_d;
		popped_q <= popped_d;
		ai_q     <= ai_d;
		if (cmd_emits(cmd)) begin
			res_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_sort_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_SORT_CMP) |-> ((i_q < j_q) && (COUNT_W'(j_q) < count_q)))
		else $error("sort indexes out of order or past the held entries");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_PUSH) |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("push did not advance the count");
`endif

endmodule

`default_nettype wire
